// ===== src/mrap_pkg.sv =====
// Shared types, constants and round functions for the Merkle auth-path block.
package mrap_pkg;

   typedef struct packed {
      logic        start_req;
      logic [63:0] leaf_hi;
      logic [63:0] leaf_lo;
      logic [31:0] leaf_index;
      logic [63:0] auth_hi;
      logic [63:0] auth_lo;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] root_hi;
      logic [63:0] root_lo;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture item, set up message and working vars
      logic round;   // run one compression round
      logic finish;  // fold digest into node, shift index
   } cmd_type;

   localparam int unsigned ROUNDS = 64;
   localparam int unsigned RND_W  = $clog2(ROUNDS);

   localparam logic [31:0] SHA_IV [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] SHA_K [0:ROUNDS-1] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] PAD_WORD = 32'h80000000;
   localparam logic [31:0] LEN_WORD = 32'd256;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== src/mrap_ctrl.sv =====
// Sequencer for one tree level: load, 64 rounds, finish, optional result.
module mrap_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mrap_pkg::cmd_type           cmd,
   output logic [mrap_pkg::RND_W-1:0]  rnd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [mrap_pkg::RND_W-1:0] rnd_ff, rnd_in;
   logic                       last_ff, last_in;
   logic                       rspv_ff, rspv_in;

   // a new item may enter only once the previous root has been taken
   assign req_ready = (state_ff == ST_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rnd       = rnd_ff;

   always_comb begin
      state_in   = state_ff;
      rnd_in     = rnd_ff;
      last_in    = last_ff;
      rspv_in    = rspv_ff && !rsp_ready;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               last_in  = req_last;
               rnd_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 1'b1;
            if (rnd_ff == mrap_pkg::RND_W'(mrap_pkg::ROUNDS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            rspv_in    = last_ff;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rspv_ff  <= 1'b0;
         rnd_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         rnd_ff   <= rnd_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== src/mrap_dp.sv =====
// SHA-256 round datapath with node and index registers.
module mrap_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  mrap_pkg::cmd_type           cmd,
   input  logic [mrap_pkg::RND_W-1:0]  rnd,
   input  mrap_pkg::req_type           req,
   output mrap_pkg::rsp_type           rsp
);

   logic [63:0] node_hi_ff, node_hi_in, node_lo_ff, node_lo_in;
   logic [31:0] idx_ff, idx_in;
   logic [31:0] w_ff [0:15];
   logic [31:0] w_in [0:15];
   logic [31:0] v_ff [0:7];
   logic [31:0] v_in [0:7];

   logic [63:0] cur_hi, cur_lo;
   logic [31:0] cur_idx, wnew, t1, t2, s1, s0, ch, mj;
   logic [255:0] msg;

   always_comb begin
      // load: pick node (leaf on start) and order by index bit 0
      cur_hi  = req.start_req ? req.leaf_hi    : node_hi_ff;
      cur_lo  = req.start_req ? req.leaf_lo    : node_lo_ff;
      cur_idx = req.start_req ? req.leaf_index : idx_ff;
      msg = cur_idx[0] ? {req.auth_hi, req.auth_lo, cur_hi, cur_lo}
                       : {cur_hi, cur_lo, req.auth_hi, req.auth_lo};

      s1 = mrap_pkg::rotr(v_ff[4], 6) ^ mrap_pkg::rotr(v_ff[4], 11)
         ^ mrap_pkg::rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + mrap_pkg::SHA_K[rnd] + w_ff[0];
      s0 = mrap_pkg::rotr(v_ff[0], 2) ^ mrap_pkg::rotr(v_ff[0], 13)
         ^ mrap_pkg::rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = s0 + mj;
      wnew = w_ff[0] + mrap_pkg::sig0(w_ff[1]) + w_ff[9] + mrap_pkg::sig1(w_ff[14]);

      w_in       = w_ff;
      v_in       = v_ff;
      node_hi_in = node_hi_ff;
      node_lo_in = node_lo_ff;
      idx_in     = idx_ff;
      priority if (cmd.load) begin
         for (int i = 0; i < 8; i++) begin
            w_in[i] = msg[255 - 32*i -: 32];
            v_in[i] = mrap_pkg::SHA_IV[i];
         end
         w_in[8] = mrap_pkg::PAD_WORD;
         for (int i = 9; i < 15; i++) w_in[i] = '0;
         w_in[15] = mrap_pkg::LEN_WORD;
         idx_in   = cur_idx;
      end else if (cmd.round) begin
         // slide the schedule window; word 0 is this round's word
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wnew;
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end else if (cmd.finish) begin
         node_hi_in = {v_ff[0] + mrap_pkg::SHA_IV[0], v_ff[1] + mrap_pkg::SHA_IV[1]};
         node_lo_in = {v_ff[2] + mrap_pkg::SHA_IV[2], v_ff[3] + mrap_pkg::SHA_IV[3]};
         idx_in     = idx_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_hi_ff <= '0;
         node_lo_ff <= '0;
         idx_ff     <= '0;
      end else begin
         node_hi_ff <= node_hi_in;
         node_lo_ff <= node_lo_in;
         idx_ff     <= idx_in;
      end
      w_ff <= w_in;
      v_ff <= v_in;
   end

   assign rsp.root_hi = node_hi_ff;
   assign rsp.root_lo = node_lo_ff;

endmodule

// ===== src/merkle_root_from_auth_path.sv =====
// Each accepted transfer climbs one tree level: the held node (or the leaf, when
// start_req is set) is paired with auth in the order chosen by bit 0 of the path
// index, hashed with SHA-256 and truncated to 16 bytes; the index then shifts
// right. An item takes one load step, 64 rounds of the single shared compression
// round unit, and one finish step to fold the digest into the node. An item with
// last set offers the root on rsp; the next request waits until that root
// transfer completes. Node and index persist between items, starting at zero.
module merkle_root_from_auth_path (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mrap_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mrap_pkg::rsp_type    rsp_data
);

   mrap_pkg::cmd_type          cmd;
   logic [mrap_pkg::RND_W-1:0] rnd;

   // sequence the load, rounds and finish
   mrap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .rnd       (rnd)
   );

   // hold node, index and compression state
   mrap_dp u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rnd   (rnd),
      .req   (req_data),
      .rsp   (rsp_data)
   );

   // never take a request while a root is pending
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request accepted with root pending");

   // at most one command a cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("overlapping datapath commands");

   // root stays put while waiting
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("root changed while stalled");

endmodule
